// ----- hdl/fhs_pkg.sv -----
// ----------------------------------------------------------------------------
// fhs_pkg
// shared types and constants of the fragmentation heuristic scanner
// ----------------------------------------------------------------------------
package fhs_pkg;

	// sample limits (defaults for the top level parameters)
	localparam int unsigned HEAD_SAMPLE_MAX_DEF = 65536;
	localparam int unsigned TAIL_SAMPLE_MAX_DEF = 1024;

	// fixed widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned MARK_W  = 16;
	localparam int unsigned RUN_W   = 17;
	localparam int unsigned BLK_W   = 3;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CAUSE_W = 2;
	localparam int unsigned WIN_W   = 24;
	localparam int unsigned FILL_W  = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILE_KIND        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_RUN_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_BLOCK_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_GAP_LIMIT = 2'd3;

	// register reset values
	localparam logic [KIND_W-1:0]  FILE_KIND_RST        = 2'd0;
	localparam logic [LIMIT_W-1:0] ZERO_RUN_LIMIT_RST   = 16'd4096;
	localparam logic [BLK_W-1:0]   ZERO_BLOCK_LIMIT_RST = 3'd2;
	localparam logic [LIMIT_W-1:0] MARKER_GAP_LIMIT_RST = 16'd16384;

	// file kinds
	localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_JPEG  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ZIP   = 2'd2;

	// verdict causes
	localparam logic [CAUSE_W-1:0] CAUSE_NONE       = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_MARKER_GAP = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_NO_CDIR    = 2'd2;
	localparam logic [CAUSE_W-1:0] CAUSE_ZERO_BLKS  = 2'd3;

	// byte values
	localparam logic [BYTE_W-1:0] MARK_PREFIX = 8'hFF;
	localparam logic [BYTE_W-1:0] MARK_LO     = 8'hC0;
	localparam logic [BYTE_W-1:0] MARK_HI     = 8'hFE;
	localparam logic [WIN_W-1:0]  CDIR_HEAD   = 24'h504B01;
	localparam logic [BYTE_W-1:0] CDIR_LAST   = 8'h02;

	localparam logic [0:0] REGION_HEAD = 1'b0;
	localparam logic [0:0] REGION_TAIL = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              region;
		logic              last;
	} in_req_t;

	typedef struct packed {
		logic               fragmented;
		logic [CAUSE_W-1:0] cause;
		logic [BLK_W-1:0]   zero_blocks;
	} out_req_t;

	typedef struct packed {
		logic               jpeg_mode;
		logic [LIMIT_W-1:0] zero_run_limit;
		logic [LIMIT_W-1:0] marker_gap_limit;
	} head_cfg_t;

	typedef struct packed {
		logic             gap_found;
		logic [BLK_W-1:0] zero_blocks;
	} head_stat_t;

	typedef struct packed {
		logic tail_seen;
		logic sig_found;
	} tail_stat_t;

endpackage

// ----- hdl/fhs_head.sv -----
// ----------------------------------------------------------------------------
// fhs_head
// head sample tracker: zero runs and jpeg marker gaps
// ----------------------------------------------------------------------------
module fhs_head import fhs_pkg::*; #(
	parameter int unsigned HEAD_SAMPLE_MAX = HEAD_SAMPLE_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              clear,
	input  logic [BYTE_W-1:0] data_byte,
	input  head_cfg_t         cfg,
	output head_stat_t        stat
);

	localparam int unsigned HPW = $clog2(HEAD_SAMPLE_MAX + 1);
	localparam int unsigned DW  = ((HPW > MARK_W) ? HPW : MARK_W) + 1;

	logic [HPW-1:0]    pos_q,  pos_d;
	logic [BYTE_W-1:0] prev_q, prev_d;
	logic [MARK_W-1:0] mark_q, mark_d;
	logic [RUN_W-1:0]  run_q,  run_d;
	logic [BLK_W-1:0]  blk_q,  blk_d;
	logic              gap_q,  gap_d;

	logic           active;
	logic           is_marker;
	logic [HPW-1:0] at;
	logic [DW-1:0]  diff;
	logic           gap_big;

	always_comb begin
		active    = take && (pos_q < HPW'(HEAD_SAMPLE_MAX));
		at        = pos_q - HPW'(1);
		// borrow means the stored position wrapped: gap is huge
		diff      = DW'(at) - DW'(mark_q);
		gap_big   = diff[DW-1] || (diff[DW-2:0] > (DW-1)'(cfg.marker_gap_limit));
		is_marker = cfg.jpeg_mode && (pos_q != '0) && (prev_q == MARK_PREFIX)
			&& (data_byte >= MARK_LO) && (data_byte <= MARK_HI);

		pos_d  = pos_q;
		prev_d = prev_q;
		mark_d = mark_q;
		run_d  = run_q;
		blk_d  = blk_q;
		gap_d  = gap_q;
		if (active) begin
			if (data_byte == '0) begin
				if (run_q != '1) begin
					run_d = run_q + RUN_W'(1);
				end
			end else begin
				if ((run_q > RUN_W'(cfg.zero_run_limit)) && (blk_q != '1)) begin
					blk_d = blk_q + BLK_W'(1);
				end
				run_d = '0;
			end
			if (is_marker) begin
				if ((mark_q != '0) && gap_big) begin
					gap_d = 1'b1;
				end
				mark_d = MARK_W'(at);
			end
			prev_d = data_byte;
			pos_d  = pos_q + HPW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= '0;
			mark_q <= '0;
			run_q  <= '0;
			blk_q  <= '0;
			gap_q  <= 1'b0;
		end else if (clear) begin
			pos_q  <= '0;
			prev_q <= '0;
			mark_q <= '0;
			run_q  <= '0;
			blk_q  <= '0;
			gap_q  <= 1'b0;
		end else begin
			pos_q  <= pos_d;
			prev_q <= prev_d;
			mark_q <= mark_d;
			run_q  <= run_d;
			blk_q  <= blk_d;
			gap_q  <= gap_d;
		end
	end

	// status including the byte being taken now
	assign stat.gap_found   = gap_d;
	assign stat.zero_blocks = blk_d;

endmodule

// ----- hdl/fhs_tail.sv -----
// ----------------------------------------------------------------------------
// fhs_tail
// tail sample tracker: central directory signature search
// ----------------------------------------------------------------------------
module fhs_tail import fhs_pkg::*; #(
	parameter int unsigned TAIL_SAMPLE_MAX = TAIL_SAMPLE_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              clear,
	input  logic [BYTE_W-1:0] data_byte,
	output tail_stat_t        stat
);

	localparam int unsigned TPW = $clog2(TAIL_SAMPLE_MAX + 1);

	logic [TPW-1:0]    cnt_q,  cnt_d;
	logic [WIN_W-1:0]  win_q,  win_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              sig_q,  sig_d;
	logic              seen_q, seen_d;
	logic              active;

	always_comb begin
		active = take && (cnt_q < TPW'(TAIL_SAMPLE_MAX));
		cnt_d  = cnt_q;
		win_d  = win_q;
		fill_d = fill_q;
		sig_d  = sig_q;
		seen_d = seen_q;
		if (active) begin
			cnt_d  = cnt_q + TPW'(1);
			seen_d = 1'b1;
			if ((fill_q == '1) && (win_q == CDIR_HEAD) && (data_byte == CDIR_LAST)) begin
				sig_d = 1'b1;
			end
			win_d = {win_q[WIN_W-BYTE_W-1:0], data_byte};
			if (fill_q != '1) begin
				fill_d = fill_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			win_q  <= '0;
			fill_q <= '0;
			sig_q  <= 1'b0;
			seen_q <= 1'b0;
		end else if (clear) begin
			cnt_q  <= '0;
			win_q  <= '0;
			fill_q <= '0;
			sig_q  <= 1'b0;
			seen_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			win_q  <= win_d;
			fill_q <= fill_d;
			sig_q  <= sig_d;
			seen_q <= seen_d;
		end
	end

	assign stat.tail_seen = seen_d;
	assign stat.sig_found = sig_d;

endmodule

// ----- hdl/fragmentation_heuristic_scanner_core.sv -----
// ----------------------------------------------------------------------------
// fragmentation_heuristic_scanner_core
// judges from sampled head and tail bytes whether a file looks fragmented
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid, in_stall, in_data): one byte request per item,
//   with its region (head or tail) and a last flag closing the file
//   output channel (out_valid, out_stall, out_data): one verdict request
//   per file, produced only for the byte flagged last
//   configuration: cfg_wr_en, cfg_index, cfg_wdata, written while idle
// throughput and datapath
//   one byte request accepted per cycle unless in_stall is high; the
//   byte sits in the input register, the tracker update and verdict
//   logic run between it and the result register, and a verdict shows
//   on out_valid once the result register loads it
// reset
//   arst_n clears all tracking state and both channel valids and loads
//   the register defaults; after each verdict the tracking state clears
//   again while the registers keep their values
// stall
//   a held verdict stays in the result register; bytes that give no
//   verdict keep flowing past it, only a further last byte waits and
//   then in_stall rises
// ----------------------------------------------------------------------------
module fragmentation_heuristic_scanner_core import fhs_pkg::*; #(
	parameter int unsigned HEAD_SAMPLE_MAX = HEAD_SAMPLE_MAX_DEF,
	parameter int unsigned TAIL_SAMPLE_MAX = TAIL_SAMPLE_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_req_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_req_t              out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration registers
	logic [KIND_W-1:0]  file_kind_q;
	logic [LIMIT_W-1:0] zero_run_limit_q;
	logic [BLK_W-1:0]   zero_block_limit_q;
	logic [LIMIT_W-1:0] marker_gap_limit_q;

	// input register
	logic    valid_s1;
	in_req_t req_s1;

	// result register
	logic     out_valid_q;
	out_req_t out_q;

	logic       fire_s1;
	logic       accept_in;
	logic       done_s1;
	head_cfg_t  head_cfg;
	head_stat_t head_stat;
	tail_stat_t tail_stat;
	logic [CAUSE_W-1:0] cause;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_kind_q        <= FILE_KIND_RST;
			zero_run_limit_q   <= ZERO_RUN_LIMIT_RST;
			zero_block_limit_q <= ZERO_BLOCK_LIMIT_RST;
			marker_gap_limit_q <= MARKER_GAP_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FILE_KIND:        file_kind_q        <= cfg_wdata[KIND_W-1:0];
				REG_ZERO_RUN_LIMIT:   zero_run_limit_q   <= cfg_wdata[LIMIT_W-1:0];
				REG_ZERO_BLOCK_LIMIT: zero_block_limit_q <= cfg_wdata[BLK_W-1:0];
				REG_MARKER_GAP_LIMIT: marker_gap_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// a byte without last never needs the result register
	assign fire_s1   = valid_s1 && (!req_s1.last || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !fire_s1;
	assign accept_in = in_valid && !in_stall;
	assign done_s1   = fire_s1 && req_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_s1 <= in_data;
		end
	end

	assign head_cfg.jpeg_mode        = (file_kind_q == KIND_JPEG);
	assign head_cfg.zero_run_limit   = zero_run_limit_q;
	assign head_cfg.marker_gap_limit = marker_gap_limit_q;

	fhs_head #(
		.HEAD_SAMPLE_MAX(HEAD_SAMPLE_MAX)
	) u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (fire_s1 && (req_s1.region == REGION_HEAD)),
		.clear     (done_s1),
		.data_byte (req_s1.data_byte),
		.cfg       (head_cfg),
		.stat      (head_stat)
	);

	fhs_tail #(
		.TAIL_SAMPLE_MAX(TAIL_SAMPLE_MAX)
	) u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (fire_s1 && (req_s1.region == REGION_TAIL)),
		.clear     (done_s1),
		.data_byte (req_s1.data_byte),
		.stat      (tail_stat)
	);

	// verdict priority: marker gap, missing central directory, zero blocks
	always_comb begin
		if ((file_kind_q == KIND_JPEG) && head_stat.gap_found) begin
			cause = CAUSE_MARKER_GAP;
		end else if ((file_kind_q == KIND_ZIP) && tail_stat.tail_seen
			&& !tail_stat.sig_found) begin
			cause = CAUSE_NO_CDIR;
		end else if (head_stat.zero_blocks > zero_block_limit_q) begin
			cause = CAUSE_ZERO_BLKS;
		end else begin
			cause = CAUSE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			out_q.fragmented  <= (cause != CAUSE_NONE);
			out_q.cause       <= cause;
			out_q.zero_blocks <= head_stat.zero_blocks;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- sim/fragmentation_heuristic_scanner_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragmentation_heuristic_scanner_core_test
// self-checking bench: streams head and tail byte requests through the
// scanner, predicts every verdict alongside, and compares them field by field
// ----------------------------------------------------------------------------
module fragmentation_heuristic_scanner_core_test import fhs_pkg::*;;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SHOWN_MAX   = 10;
	localparam int SETTLE_CYC  = 4;
	localparam int ITEMS_PER_SETTING = 40;

	// verdict predictor: own copy of registers and tracking state, plus the
	// verdicts still owed by the block
	class verdict_predictor;
		logic [KIND_W-1:0]  kind;
		logic [LIMIT_W-1:0] run_limit;
		logic [BLK_W-1:0]   block_limit;
		logic [LIMIT_W-1:0] gap_limit;

		int unsigned        head_pos;
		logic [BYTE_W-1:0]  prev_byte;
		logic [MARK_W-1:0]  mark_pos;
		logic [RUN_W-1:0]   run_len;
		logic [BLK_W-1:0]   blocks;
		logic               gap_seen;
		logic [WIN_W-1:0]   tail_win;
		logic [FILL_W-1:0]  tail_fill;
		logic               sig_seen;
		logic               tail_any;
		int unsigned        tail_count;

		out_req_t due[$];
		int errors;

		function new();
			kind        = FILE_KIND_RST;
			run_limit   = ZERO_RUN_LIMIT_RST;
			block_limit = ZERO_BLOCK_LIMIT_RST;
			gap_limit   = MARKER_GAP_LIMIT_RST;
			errors      = 0;
			clear();
		endfunction

		function void clear();
			head_pos   = 0;
			prev_byte  = '0;
			mark_pos   = '0;
			run_len    = '0;
			blocks     = '0;
			gap_seen   = 1'b0;
			tail_win   = '0;
			tail_fill  = '0;
			sig_seen   = 1'b0;
			tail_any   = 1'b0;
			tail_count = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
			REG_FILE_KIND:        kind        = val[KIND_W-1:0];
			REG_ZERO_RUN_LIMIT:   run_limit   = val[LIMIT_W-1:0];
			REG_ZERO_BLOCK_LIMIT: block_limit = val[BLK_W-1:0];
			REG_MARKER_GAP_LIMIT: gap_limit   = val[LIMIT_W-1:0];
			default: ;
			endcase
		endfunction

		function void note_byte(in_req_t r);
			int unsigned at;
			logic [CAUSE_W-1:0] c;
			out_req_t v;
			if (r.region == REGION_TAIL) begin
				if (tail_count < TAIL_SAMPLE_MAX_DEF) begin
					tail_count++;
					tail_any = 1'b1;
					if (tail_fill == 2'd3 && tail_win == CDIR_HEAD && r.data_byte == CDIR_LAST)
						sig_seen = 1'b1;
					tail_win = {tail_win[WIN_W-BYTE_W-1:0], r.data_byte};
					if (tail_fill != 2'd3)
						tail_fill++;
				end
			end else if (head_pos < HEAD_SAMPLE_MAX_DEF) begin
				// a zero run only counts once a nonzero head byte closes it
				if (r.data_byte == '0) begin
					if (run_len != '1)
						run_len++;
				end else begin
					if (run_len > {1'b0, run_limit} && blocks != '1)
						blocks++;
					run_len = '0;
				end
				if (kind == KIND_JPEG && head_pos > 0 && prev_byte == MARK_PREFIX &&
						r.data_byte >= MARK_LO && r.data_byte <= MARK_HI) begin
					at = head_pos - 1;
					if (mark_pos != '0 && (at - mark_pos) > gap_limit)
						gap_seen = 1'b1;
					mark_pos = at[MARK_W-1:0];
				end
				prev_byte = r.data_byte;
				head_pos++;
			end
			if (r.last) begin
				if (kind == KIND_JPEG && gap_seen)
					c = CAUSE_MARKER_GAP;
				else if (kind == KIND_ZIP && tail_any && !sig_seen)
					c = CAUSE_NO_CDIR;
				else if (blocks > block_limit)
					c = CAUSE_ZERO_BLKS;
				else
					c = CAUSE_NONE;
				v.fragmented  = (c != CAUSE_NONE);
				v.cause       = c;
				v.zero_blocks = blocks;
				due.push_back(v);
				clear();
			end
		endfunction

		function void check_verdict(out_req_t got);
			out_req_t want;
			if (due.size() == 0) begin
				errors++;
				if (errors <= SHOWN_MAX)
					$display("unexpected verdict: frag=%0d cause=%0d blocks=%0d",
						got.fragmented, got.cause, got.zero_blocks);
				return;
			end
			want = due.pop_front();
			if (got.fragmented !== want.fragmented || got.cause !== want.cause ||
					got.zero_blocks !== want.zero_blocks) begin
				errors++;
				if (errors <= SHOWN_MAX)
					$display("verdict mismatch: expected frag=%0d cause=%0d blocks=%0d, got frag=%0d cause=%0d blocks=%0d",
						want.fragmented, want.cause, want.zero_blocks,
						got.fragmented, got.cause, got.zero_blocks);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_req_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_req_t              out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	verdict_predictor verdicts = new();

	// idle and stall odds in percent, set per phase
	int gap_pct   = 0;
	int stall_pct = 0;
	// long receiver hold-off, counted down by the receiver process
	int hold_left = 0;
	int cycle_count = 0;

	fragmentation_heuristic_scanner_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// safety net against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when one is requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// every verdict taken off the output channel is checked in order
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			verdicts.check_verdict(out_data);
	end

	function automatic in_req_t mk(logic [BYTE_W-1:0] b, logic rgn);
		in_req_t r;
		r.data_byte = b;
		r.region    = rgn;
		r.last      = 1'b0;
		return r;
	endfunction

	// offers one byte request; called and returns at a falling edge, valid
	// stays high so back-to-back requests need no extra step
	task automatic push_byte(input in_req_t r);
		logic [$bits(in_req_t)-1:0] junk;
		bit taken;
		while ($urandom_range(0, 99) < gap_pct) begin
			junk = $bits(in_req_t)'($urandom);
			in_valid <= 1'b0;
			in_data  <= junk;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			if (!in_stall) begin
				taken = 1;
				verdicts.note_byte(r);
			end
			@(negedge clk);
		end
	endtask

	// one file: the final byte carries the last flag
	task automatic send_file(input in_req_t q[$]);
		q[q.size()-1].last = 1'b1;
		foreach (q[i])
			push_byte(q[i]);
	endtask

	// drop valid, let owed verdicts drain, then give the pipeline time to
	// finish bytes that owe nothing
	task automatic settle();
		in_valid <= 1'b0;
		while (verdicts.due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// writes all four registers, one per cycle, block idle
	task automatic load_regs(input logic [CFG_DATA_W-1:0] k, input logic [CFG_DATA_W-1:0] run,
			input logic [CFG_DATA_W-1:0] blk, input logic [CFG_DATA_W-1:0] gap);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx[0] = REG_FILE_KIND;        val[0] = k;
		idx[1] = REG_ZERO_RUN_LIMIT;   val[1] = run;
		idx[2] = REG_ZERO_BLOCK_LIMIT; val[2] = blk;
		idx[3] = REG_MARKER_GAP_LIMIT; val[3] = gap;
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			verdicts.write_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic directed_files();
		in_req_t q[$];
		// jpeg: marker at position zero is not a reference, a tail byte inside
		// a zero run does not break it, FF BF is no marker, FF FF D8 is, and
		// the next marker lands above the gap limit
		load_regs(CFG_DATA_W'(KIND_JPEG), 16'd1, 16'd0, 16'd2);
		q = '{mk(MARK_PREFIX, REGION_HEAD), mk(MARK_LO, REGION_HEAD),
			mk(8'h00, REGION_HEAD), mk(8'h00, REGION_TAIL), mk(8'h00, REGION_HEAD),
			mk(MARK_PREFIX, REGION_HEAD), mk(8'hBF, REGION_HEAD),
			mk(MARK_PREFIX, REGION_HEAD), mk(MARK_PREFIX, REGION_HEAD), mk(8'hD8, REGION_HEAD),
			mk(8'h11, REGION_HEAD), mk(MARK_PREFIX, REGION_HEAD), mk(MARK_HI, REGION_HEAD)};
		send_file(q);
		settle();
		// zip: signature present, open zero run at the end is not counted
		load_regs(CFG_DATA_W'(KIND_ZIP), 16'd0, 16'd7, 16'hFFFF);
		q = '{mk(8'h00, REGION_HEAD), mk(CDIR_HEAD[23:16], REGION_TAIL),
			mk(CDIR_HEAD[15:8], REGION_TAIL), mk(CDIR_HEAD[7:0], REGION_TAIL),
			mk(CDIR_LAST, REGION_TAIL), mk(8'h00, REGION_HEAD)};
		send_file(q);
		// zip: broken signature
		q = '{mk(CDIR_HEAD[23:16], REGION_TAIL), mk(CDIR_HEAD[15:8], REGION_TAIL),
			mk(CDIR_HEAD[7:0], REGION_TAIL), mk(8'h03, REGION_TAIL)};
		send_file(q);
		settle();
		// unused kind acts as other, upper data bits masked off
		load_regs(16'hFFFF, 16'd0, 16'd0, 16'd0);
		q = '{mk(8'h00, REGION_HEAD), mk(8'h7F, REGION_HEAD)};
		send_file(q);
		settle();
	endtask

	// random file built from segments: zero runs, markers (mostly valid),
	// nonzero filler, tail signatures (sometimes broken), tail bytes, noise
	task automatic random_file(output int count);
		in_req_t q[$];
		logic [BYTE_W-1:0] b;
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 6))
			0: repeat ($urandom_range(1, 6)) q.push_back(mk(8'h00, REGION_HEAD));
			1: begin
				q.push_back(mk(MARK_PREFIX, REGION_HEAD));
				b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(MARK_LO, MARK_HI))
					: 8'($urandom);
				q.push_back(mk(b, REGION_HEAD));
			end
			2: repeat ($urandom_range(1, 5))
				q.push_back(mk(8'($urandom_range(1, 255)), REGION_HEAD));
			3: begin
				q.push_back(mk(CDIR_HEAD[23:16], REGION_TAIL));
				q.push_back(mk(CDIR_HEAD[15:8], REGION_TAIL));
				q.push_back(mk(CDIR_HEAD[7:0], REGION_TAIL));
				b = ($urandom_range(0, 3) != 0) ? CDIR_LAST : 8'($urandom);
				q.push_back(mk(b, REGION_TAIL));
			end
			4: repeat ($urandom_range(1, 4)) q.push_back(mk(8'($urandom), REGION_TAIL));
			default: repeat ($urandom_range(1, 3))
				q.push_back(mk(8'($urandom), 1'($urandom)));
			endcase
		end
		send_file(q);
		count = q.size();
	endtask

	// mode 0 random (small limits so runs and gaps trip), 1 all minimum,
	// 2 all maximum
	task automatic pick_regs(input int mode);
		logic [CFG_DATA_W-1:0] k, run, blk, gap;
		k   = {14'($urandom), 2'($urandom_range(0, 3))};
		run = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
		blk = {13'($urandom), 3'($urandom_range(0, 7))};
		gap = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 12));
		if (mode == 1)
			load_regs(CFG_DATA_W'(KIND_OTHER), 16'd0, 16'd0, 16'd0);
		else if (mode == 2)
			load_regs(16'd3, 16'hFFFF, 16'd7, 16'hFFFF);
		else
			load_regs(k, run, blk, gap);
	endtask

	initial begin
		int n;
		int sent;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_files();

		// phases: no idling, sender idle, receiver stalling, both a little
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 78; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 78; end
			default: begin gap_pct = 16; stall_pct = 16; end
			endcase
			for (int s = 0; s < 3; s++) begin
				settle();
				if (ph == 0 && s == 0)
					pick_regs(1);
				else if (ph == 3 && s == 2)
					pick_regs(2);
				else
					pick_regs(0);
				// receiver holds off while the sender keeps pushing, so
				// verdicts back up and the input stalls
				if (ph == 0 && s == 1)
					hold_left = 300;
				sent = 0;
				while (sent < ITEMS_PER_SETTING) begin
					random_file(n);
					sent += n;
				end
			end
		end

		in_valid <= 1'b0;
		while (verdicts.due.size() != 0)
			@(negedge clk);
		repeat (2 * SETTLE_CYC) @(negedge clk);

		if (verdicts.errors == 0 && verdicts.due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
